// ===== sv/bpht_pkg.sv =====
package bpht_pkg;

  localparam int DEF_TABLE_SLOTS = 256;
  localparam int DATA_W          = 32;
  localparam int DIST_W          = 6;
  localparam int STATUS_W        = 3;
  localparam int COUNT_OUT_W     = 9;

  // request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_HIT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF  = 3'd4;

  localparam logic [DATA_W-1:0] HASH_MASK31 = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] default_value;
  } bpht_item_t;

  localparam int ITEM_W = $bits(bpht_item_t);

  // 32-bit integer mix; the multiply by 2057 is shift-and-add
  function automatic logic [DATA_W-1:0] mix32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] a;
    a = ~x + (x << 15);
    a = a ^ (a >> 12);
    a = a + (a << 2);
    a = a ^ (a >> 4);
    a = a + (a << 3) + (a << 11);
    a = a ^ (a >> 16);
    return a & HASH_MASK31;
  endfunction

endpackage

// ===== sv/bpht_ifs.sv =====
interface bpht_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] key;
  logic signed [31:0] value;
  logic signed [31:0] default_value;

  modport source (output valid, req_type, key, value, default_value, input ready);
  modport sink   (input valid, req_type, key, value, default_value, output ready);
endinterface

interface bpht_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic signed [31:0] evicted_key;
  logic signed [31:0] evicted_value;
  logic [8:0]         entry_count;

  modport source (output valid, status, result_value, evicted_key, evicted_value,
                  entry_count, input ready);
  modport sink   (input valid, status, result_value, evicted_key, evicted_value,
                  entry_count, output ready);
endinterface

// ===== sv/bounded_probe_hash_table.sv =====
// A lookup probes up to log2(N)+2 slots from its home slot, reading each in S_RD and examining it in S_EV;
// an insert makes up to two probe passes, and a delete adds a backward shift (S_BS_RD, S_BS_EV, S_BS_CLR).
// Throughput: one request at a time in the probe sequencer, whose slot memory, with one read and one
// write port, sets the pace; the input stage and a 2-entry queue take requests meanwhile.
// Reset: synchronous; a clearing pass over all TABLE_SLOTS slots marks every slot empty,
// and no request starts until it ends.
module bounded_probe_hash_table #(
  parameter int TABLE_SLOTS = bpht_pkg::DEF_TABLE_SLOTS
) (
  input logic        clk,
  input logic        rst,
  bpht_req_if.sink   req,
  bpht_rsp_if.source rsp
);
  import bpht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int QW    = ITEM_W + IDX_W;

  logic          push;
  logic [QW-1:0] push_data;
  logic          push_ready;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          pop_valid;

  bpht_front #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .push(push), .push_data(push_data), .push_ready(push_ready)
  );

  bpht_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .push_ready(push_ready),
    .pop(pop), .pop_data(pop_data), .pop_valid(pop_valid)
  );

  bpht_engine #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_engine (
    .clk(clk), .rst(rst),
    .q_valid(pop_valid), .q_data(pop_data), .q_pop(pop),
    .rsp(rsp)
  );

endmodule

// ===== sv/bpht_front.sv =====
module bpht_front #(
  parameter int TABLE_SLOTS = 256,
  parameter int IDX_W       = $clog2(TABLE_SLOTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  bpht_req_if.sink                            req,
  output logic                                push,
  output logic [bpht_pkg::ITEM_W+IDX_W-1:0]   push_data,
  input  logic                                push_ready
);
  import bpht_pkg::*;

  logic       item_valid;
  bpht_item_t item;
  logic [DATA_W-1:0] hash;

  // input stage: refill whenever empty or draining into the queue
  assign req.ready = !item_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item <= '{req_type: req.req_type, key: req.key, value: req.value,
                default_value: req.default_value};
    end
  end

  // home slot classification
  assign hash      = mix32(item.key);
  assign push      = item_valid;
  assign push_data = {item, hash[IDX_W-1:0]};

endmodule

// ===== sv/bpht_queue.sv =====
module bpht_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);
  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/bpht_engine.sv =====
module bpht_engine #(
  parameter int TABLE_SLOTS = 256,
  parameter int IDX_W       = $clog2(TABLE_SLOTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  logic [bpht_pkg::ITEM_W+IDX_W-1:0]   q_data,
  output logic                                q_pop,
  bpht_rsp_if.source                          rsp
);
  import bpht_pkg::*;

  localparam int MAXD   = IDX_W + 2;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int WORD_W = 1 + DIST_W + 2 * DATA_W;
  localparam logic [DIST_W-1:0] DMAX  = DIST_W'(MAXD);
  localparam logic [DIST_W-1:0] DBEST = DIST_W'(MAXD - 1);
  localparam logic [CNT_W-1:0]  NSLOT = CNT_W'(TABLE_SLOTS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_EV     = 4'd3;
  localparam logic [3:0] S_END    = 4'd4;
  localparam logic [3:0] S_BS_RD  = 4'd5;
  localparam logic [3:0] S_BS_EV  = 4'd6;
  localparam logic [3:0] S_BS_CLR = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;

  // slot memory: {occupied, distance, key, value}
  logic [WORD_W-1:0] mem [TABLE_SLOTS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we;

  // request context
  bpht_item_t        q_item;
  logic [IDX_W-1:0]  q_home;
  logic [1:0]        rtype;
  logic [DATA_W-1:0] k;
  logic [DATA_W-1:0] v;
  logic [DATA_W-1:0] defv;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  idx;
  logic [DIST_W-1:0] d;
  logic [DIST_W-1:0] best;
  logic              cv;
  logic              reins;
  logic [1:0]        moves;
  logic [IDX_W-1:0]  cidx;
  logic [DATA_W-1:0] ckey;
  logic [DATA_W-1:0] cval;
  logic [DIST_W-1:0] cdist;
  logic [IDX_W-1:0]  hole;
  logic [IDX_W-1:0]  clr;
  logic [CNT_W-1:0]  count;

  // result under construction and output register
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   res_value;
  logic [DATA_W-1:0]   res_ek;
  logic [DATA_W-1:0]   res_ev;
  logic                out_valid;

  // slot decode
  logic              r_occ;
  logic [DIST_W-1:0] r_dist;
  logic [DATA_W-1:0] r_key;
  logic [DATA_W-1:0] r_val;
  logic              same_home;
  logic              match;
  logic              take_cand;
  logic [DIST_W-1:0] d_inc;
  logic              out_free;

  assign {q_item, q_home} = q_data;
  assign {r_occ, r_dist, r_key, r_val} = rdata;
  assign same_home = ((idx - IDX_W'(r_dist)) == home);
  assign match     = r_occ && same_home && !reins && (r_key == k);
  assign take_cand = r_occ && !same_home && (r_dist <= best);
  assign d_inc     = d + DIST_W'(1);
  assign out_free  = !out_valid || rsp.ready;
  assign q_pop     = (state == S_IDLE) && q_valid;

  // memory read address
  always_comb begin
    raddr = idx;
    if (state == S_BS_RD) raddr = hole + IDX_W'(d);
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
      end
      S_EV: begin
        if (!r_occ && rtype == REQ_INSERT) begin
          we    = 1'b1;
          wdata = {1'b1, d, k, v};
        end else if (match && rtype == REQ_INSERT) begin
          we    = 1'b1;
          wdata = {1'b1, r_dist, k, v};
        end else if (match && rtype == REQ_DELETE) begin
          we    = 1'b1;
          wdata = {1'b0, r_dist, r_key, r_val};
        end
      end
      S_END: begin
        if (rtype == REQ_INSERT && cv && count < NSLOT) begin
          we    = 1'b1;
          waddr = cidx;
          wdata = {1'b1, best, k, v};
        end
      end
      S_BS_EV: begin
        if (r_occ && r_dist >= d) begin
          we    = 1'b1;
          waddr = hole;
          wdata = {1'b1, r_dist - d, r_key, r_val};
        end
      end
      S_BS_CLR: begin
        we    = 1'b1;
        waddr = hole;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: load on completion, clear on transfer
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.ready)            out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + IDX_W'(1);
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            rtype      <= q_item.req_type;
            k          <= q_item.key;
            v          <= q_item.value;
            defv       <= q_item.default_value;
            home       <= q_home;
            idx        <= q_home;
            d          <= '0;
            best       <= DBEST;
            cv         <= 1'b0;
            reins      <= 1'b0;
            moves      <= '0;
            res_status <= ST_MISS;
            res_value  <= '0;
            res_ek     <= '0;
            res_ev     <= '0;
            if (q_item.req_type == REQ_LOOKUP || q_item.req_type == REQ_INSERT ||
                q_item.req_type == REQ_DELETE) begin
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          if (!r_occ) begin
            if (rtype == REQ_INSERT) begin
              count      <= count + CNT_W'(1);
              res_status <= ST_NEW;
            end else if (rtype == REQ_LOOKUP) begin
              res_value <= defv;
            end
            state <= S_DONE;
          end else if (match) begin
            priority if (rtype == REQ_LOOKUP) begin
              res_status <= ST_HIT;
              res_value  <= r_val;
              state      <= S_DONE;
            end else if (rtype == REQ_INSERT) begin
              res_status <= ST_UPD;
              state      <= S_DONE;
            end else begin
              res_status <= ST_UPD;
              if (count != '0) count <= count - CNT_W'(1);
              hole  <= idx;
              d     <= DIST_W'(1);
              state <= S_BS_RD;
            end
          end else begin
            if (take_cand) begin
              best  <= d;
              cv    <= 1'b1;
              cidx  <= idx;
              ckey  <= r_key;
              cval  <= r_val;
              cdist <= r_dist;
            end
            if (d_inc < DMAX) begin
              d     <= d_inc;
              idx   <= idx + IDX_W'(1);
              state <= S_RD;
            end else begin
              state <= S_END;
            end
          end
        end
        S_END: begin
          if (rtype != REQ_INSERT) begin
            if (rtype == REQ_LOOKUP) res_value <= defv;
            state <= S_DONE;
          end else if (cv && count < NSLOT) begin
            // displace candidate, carry its entry on
            k     <= ckey;
            v     <= cval;
            home  <= cidx - IDX_W'(cdist);
            d     <= cdist + DIST_W'(1);
            idx   <= cidx + IDX_W'(1);
            reins <= 1'b1;
            moves <= moves + 2'd1;
            best  <= DBEST;
            cv    <= 1'b0;
            if (moves == 2'd1) begin
              res_status <= ST_OVF;
              res_ek     <= ckey;
              res_ev     <= cval;
              state      <= S_DONE;
            end else if (cdist + DIST_W'(1) < DMAX) begin
              state <= S_RD;
            end else begin
              state <= S_END;
            end
          end else begin
            res_status <= ST_OVF;
            res_ek     <= k;
            res_ev     <= v;
            state      <= S_DONE;
          end
        end
        S_BS_RD: state <= S_BS_EV;
        S_BS_EV: begin
          if (r_occ && r_dist >= d) begin
            hole  <= hole + IDX_W'(d);
            state <= S_BS_CLR;
          end else if (d_inc < DMAX) begin
            d     <= d_inc;
            state <= S_BS_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_BS_CLR: begin
          d     <= DIST_W'(1);
          state <= S_BS_RD;
        end
        S_DONE: begin
          if (out_free) begin
            rsp.status        <= res_status;
            rsp.result_value  <= res_value;
            rsp.evicted_key   <= res_ek;
            rsp.evicted_value <= res_ev;
            rsp.entry_count   <= COUNT_OUT_W'(count);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= NSLOT)
    else $error("entry count above table size");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("request taken during clearing pass");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");
  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_EV) |-> (moves <= 2'd1))
    else $error("probe after second displacement");

endmodule
